FILE: rtl/sldp_pkg.sv
// ----------------------------------------------------------------------------
// sldp_pkg
// Shared types and constants of the slew-limited drive profiler.
// ----------------------------------------------------------------------------
package sldp_pkg;

  // Configuration register map
  typedef enum logic [2:0] {
    REG_TARGET_TICKS   = 3'd0,
    REG_DIST_GAIN      = 3'd1,
    REG_DECEL_GAIN     = 3'd2,
    REG_SLEW_LIMIT     = 3'd3,
    REG_ALIGN_GAIN     = 3'd4,
    REG_MIN_POWER      = 3'd5,
    REG_POWER_CAP      = 3'd6,
    REG_DIRECTION_MODE = 3'd7
  } cfg_reg_t;

  typedef enum logic [1:0] {
    DIR_FORWARD    = 2'd0,
    DIR_BACKWARD   = 2'd1,
    DIR_SPIN_LEFT  = 2'd2,
    DIR_SPIN_RIGHT = 2'd3
  } dir_mode_t;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 20;

  localparam int unsigned TGT_W   = 20;
  localparam int unsigned GAIN_W  = 16;
  localparam int unsigned DECEL_W = 12;
  localparam int unsigned SLEW_W  = 20;
  localparam int unsigned PWR_W   = 10;
  localparam int unsigned VEL_W   = 11;

  // gains are Q0.16, slew limit Q0.20, decel gain Q4.8
  localparam int unsigned GAIN_FRAC  = 16;
  localparam int unsigned SLEW_FRAC  = 20;
  localparam int unsigned DECEL_FRAC = 8;

  localparam logic [PWR_W-1:0] OUT_MAX = 10'd1023;

  // result word: left velocity, right velocity, done flag, pad
  localparam int unsigned OUT_W    = 24;
  localparam int unsigned OUT_L_LO = 0;
  localparam int unsigned OUT_R_LO = 11;
  localparam int unsigned OUT_DONE = 22;

  localparam logic [TGT_W-1:0]   RST_TARGET_TICKS = 20'd0;
  localparam logic [GAIN_W-1:0]  RST_DIST_GAIN    = 16'd131;
  localparam logic [DECEL_W-1:0] RST_DECEL_GAIN   = 12'd486;
  localparam logic [SLEW_W-1:0]  RST_SLEW_LIMIT   = 20'd4194;
  localparam logic [GAIN_W-1:0]  RST_ALIGN_GAIN   = 16'd9830;
  localparam logic [PWR_W-1:0]   RST_MIN_POWER    = 10'd5;
  localparam logic [PWR_W-1:0]   RST_POWER_CAP    = 10'd200;

endpackage

FILE: rtl/sldp_sat.sv
// ----------------------------------------------------------------------------
// sldp_sat
// Fixed-point power to velocity command: truncate toward zero, saturate +-1023.
// ----------------------------------------------------------------------------
module sldp_sat
  import sldp_pkg::*;
#(
  parameter int unsigned VW   = 40,
  parameter int unsigned FRAC = 20
) (
  input  logic signed [VW-1:0]    p,
  output logic        [VEL_W-1:0] v
);

  logic          neg;
  logic [VW-1:0] mag;
  logic [VW-1:0] whole;
  logic [PWR_W-1:0] sat;

  always_comb begin
    neg   = p[VW-1];
    mag   = neg ? (VW'(0) - VW'(p)) : VW'(p);
    whole = mag >> FRAC;
    sat   = (whole > VW'(OUT_MAX)) ? OUT_MAX : whole[PWR_W-1:0];
    v     = neg ? (VEL_W'(0) - {1'b0, sat}) : {1'b0, sat};
  end

endmodule

FILE: rtl/slew_limited_drive_profiler_unit.sv
// ----------------------------------------------------------------------------
// slew_limited_drive_profiler_unit
// Per-tick drive profile: slew-limited proportional power with decel, floor,
// left/right alignment, direction signing and power cap.
// ----------------------------------------------------------------------------
// One encoder sample pair is taken per clock while the output is not stalled;
// each result passes through the stage 1 register, then the result
// register. Stage 1 forms the tick average, remaining distance, the
// slew-clamped step and the alignment term; stage 2 closes the running power
// loop (decel multiply and compare, step add, cap clamp) combinationally, which
// is what lets one item be taken per cycle. Config writes are taken at any
// time on the cfg channel and must only happen while no item is in flight.
module slew_limited_drive_profiler_unit
  import sldp_pkg::*;
#(
  parameter int unsigned TICK_BITS       = 20,
  parameter int unsigned POWER_FRAC_BITS = 20,
  localparam int unsigned IN_W = ((1 + 2 * TICK_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,

  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [0] start_move, then left_ticks, right_ticks (TICK_BITS each), zero pad
  input  logic [IN_W-1:0]       in_tdata,

  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [10:0] left_velocity, [21:11] right_velocity, [22] move_done, [23] zero
  output logic [OUT_W-1:0]      out_tdata,

  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned T   = TICK_BITS;
  localparam int unsigned F   = POWER_FRAC_BITS;
  localparam int unsigned PDW = T + GAIN_W;
  localparam int unsigned SRW = T + GAIN_W + ((F > GAIN_FRAC) ? F - GAIN_FRAC : 0);
  localparam int unsigned SW  = SLEW_W + ((F > SLEW_FRAC) ? F - SLEW_FRAC : 0);
  localparam int unsigned RPW = PWR_W + F;
  localparam int unsigned PW  = RPW + 2;
  localparam int unsigned LW  = ((PW > SRW) ? PW : SRW) + 3;
  localparam int unsigned MW  = RPW + DECEL_W;
  localparam int unsigned RSW = T + F + DECEL_FRAC;
  localparam int unsigned CW  = (MW > RSW) ? MW : RSW;

  typedef struct packed {
    logic          start;
    logic          done;
    logic [T-1:0]  rem;
    logic [SW-1:0] step;
    logic [SRW-1:0] align;
    logic          llead;
    logic          rlead;
  } s1_t;

  // ---------------- configuration ----------------
  logic [TGT_W-1:0]   target_ticks_r;
  logic [GAIN_W-1:0]  dist_gain_r;
  logic [DECEL_W-1:0] decel_gain_r;
  logic [SLEW_W-1:0]  slew_limit_r;
  logic [GAIN_W-1:0]  align_gain_r;
  logic [PWR_W-1:0]   min_power_r;
  logic [PWR_W-1:0]   power_cap_r;
  dir_mode_t          direction_mode_r;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      target_ticks_r   <= RST_TARGET_TICKS;
      dist_gain_r      <= RST_DIST_GAIN;
      decel_gain_r     <= RST_DECEL_GAIN;
      slew_limit_r     <= RST_SLEW_LIMIT;
      align_gain_r     <= RST_ALIGN_GAIN;
      min_power_r      <= RST_MIN_POWER;
      power_cap_r      <= RST_POWER_CAP;
      direction_mode_r <= DIR_FORWARD;
    end else if (cfg_valid) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_TARGET_TICKS:   target_ticks_r   <= cfg_data[TGT_W-1:0];
        REG_DIST_GAIN:      dist_gain_r      <= cfg_data[GAIN_W-1:0];
        REG_DECEL_GAIN:     decel_gain_r     <= cfg_data[DECEL_W-1:0];
        REG_SLEW_LIMIT:     slew_limit_r     <= cfg_data[SLEW_W-1:0];
        REG_ALIGN_GAIN:     align_gain_r     <= cfg_data[GAIN_W-1:0];
        REG_MIN_POWER:      min_power_r      <= cfg_data[PWR_W-1:0];
        REG_POWER_CAP:      power_cap_r      <= cfg_data[PWR_W-1:0];
        REG_DIRECTION_MODE: direction_mode_r <= dir_mode_t'(cfg_data[1:0]);
        default: ;
      endcase
    end
  end

  // ---------------- handshake ----------------
  logic s1_v_r;
  logic out_tvalid_r;
  logic s2_rdy;
  logic in_fire;
  logic s2_load;

  assign s2_rdy     = !out_tvalid_r || out_tready;
  assign in_tready  = !s1_v_r || s2_rdy;
  assign in_fire    = in_tvalid && in_tready;
  assign s2_load    = s1_v_r && s2_rdy;
  assign out_tvalid = out_tvalid_r;

  // ---------------- stage 1: distance, step, alignment ----------------
  logic [T-1:0]     lt, rt, tgt, avg, diff;
  logic [T:0]       tick_sum;
  logic [T+GAIN_W-1:0] prod_d, prod_a;
  logic [SRW-1:0]   step_raw, align_raw;
  logic [SW-1:0]    slew;
  s1_t              s1_nxt, s1_r;

  assign lt = in_tdata[T:1];
  assign rt = in_tdata[2*T:T+1];

  always_comb begin
    tgt      = T'(target_ticks_r);
    tick_sum = {1'b0, lt} + {1'b0, rt};
    avg      = tick_sum[T:1];
    diff     = (lt > rt) ? (lt - rt) : (rt - lt);
    prod_d   = PDW'(tgt - avg) * PDW'(dist_gain_r);
    prod_a   = PDW'(diff) * PDW'(align_gain_r);
  end

  generate
    if (F >= GAIN_FRAC) begin : g_gain_up
      assign step_raw  = SRW'(prod_d) << (F - GAIN_FRAC);
      assign align_raw = SRW'(prod_a) << (F - GAIN_FRAC);
    end else begin : g_gain_dn
      assign step_raw  = SRW'(prod_d >> (GAIN_FRAC - F));
      assign align_raw = SRW'(prod_a >> (GAIN_FRAC - F));
    end
    if (F >= SLEW_FRAC) begin : g_slew_up
      assign slew = SW'(slew_limit_r) << (F - SLEW_FRAC);
    end else begin : g_slew_dn
      assign slew = SW'(slew_limit_r >> (SLEW_FRAC - F));
    end
  endgenerate

  always_comb begin
    s1_nxt.start = in_tdata[0];
    s1_nxt.done  = (avg >= tgt);
    s1_nxt.rem   = tgt - avg;
    s1_nxt.step  = (step_raw > SRW'(slew)) ? slew : step_raw[SW-1:0];
    s1_nxt.align = align_raw;
    s1_nxt.llead = (lt > rt);
    s1_nxt.rlead = (rt > lt);
  end

  // ---------------- stage 2: running power loop ----------------
  logic [RPW-1:0]        rp_r, rp_nxt, rp_eff, floor_p;
  logic [MW-1:0]         lhs;
  logic [CW-1:0]         rem_sh;
  logic                  decel;
  logic signed [PW-1:0]  rp_s, step_s, power, cap_s;
  logic signed [LW-1:0]  lp, rp, align_s;
  logic [VEL_W-1:0]      lvel, rvel;
  logic [OUT_W-1:0]      out_nxt;

  always_comb begin
    rp_eff  = s1_r.start ? '0 : rp_r;
    lhs     = MW'(rp_eff) * MW'(decel_gain_r);
    rem_sh  = CW'(s1_r.rem) << (F + DECEL_FRAC);
    // power * decel_gain beyond remaining distance, compared exactly
    decel   = CW'(lhs) > rem_sh;
    floor_p = {min_power_r, {F{1'b0}}};
    rp_s    = PW'(rp_eff);
    step_s  = PW'(s1_r.step);
    cap_s   = PW'({power_cap_r, {F{1'b0}}});

    priority if (!decel)          power = rp_s + step_s;
    else if (rp_eff < floor_p)    power = PW'(floor_p);
    else                          power = rp_s - step_s;

    align_s = LW'(s1_r.align);
    lp      = LW'(power);
    rp      = LW'(power);
    if (s1_r.llead) lp = lp - align_s;
    if (s1_r.rlead) rp = rp - align_s;

    unique case (direction_mode_r)
      DIR_BACKWARD: begin
        lp = -lp;
        rp = -rp;
      end
      DIR_SPIN_LEFT:  lp = -lp;
      DIR_SPIN_RIGHT: rp = -rp;
      DIR_FORWARD:    ;
      default:        ;
    endcase

    priority if (s1_r.done)   rp_nxt = '0;
    else if (power < 0)       rp_nxt = '0;
    else if (power > cap_s)   rp_nxt = cap_s[RPW-1:0];
    else                      rp_nxt = power[RPW-1:0];
  end

  sldp_sat #(.VW(LW), .FRAC(F)) u_sat_l (.p(lp), .v(lvel));
  sldp_sat #(.VW(LW), .FRAC(F)) u_sat_r (.p(rp), .v(rvel));

  always_comb begin
    out_nxt = '0;
    if (s1_r.done) begin
      out_nxt[OUT_DONE] = 1'b1;
    end else begin
      out_nxt[OUT_L_LO +: VEL_W] = lvel;
      out_nxt[OUT_R_LO +: VEL_W] = rvel;
    end
  end

  // ---------------- registers ----------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r       <= 1'b0;
      out_tvalid_r <= 1'b0;
      rp_r         <= '0;
    end else begin
      if (in_fire)     s1_v_r <= 1'b1;
      else if (s2_rdy) s1_v_r <= 1'b0;
      if (s2_rdy)      out_tvalid_r <= s1_v_r;
      if (s2_load)     rp_r <= rp_nxt;
    end
  end

  logic [OUT_W-1:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (in_fire) s1_r <= s1_nxt;
    if (s2_load) out_tdata_r <= out_nxt;
  end

  assign out_tdata = out_tdata_r;

endmodule

FILE: rtl/sldp_checker.sv
// ----------------------------------------------------------------------------
// sldp_checker
// Port-level checks of the drive profiler, bound to the top level.
// ----------------------------------------------------------------------------
module sldp_checker
  import sldp_pkg::*;
(
  input logic             clk,
  input logic             rst_n,
  input logic             in_tvalid,
  input logic             in_tready,
  input logic             out_tvalid,
  input logic             out_tready,
  input logic [OUT_W-1:0] out_tdata
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result changed while stalled");

  // a finished move drives both sides to zero
  a_done_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[OUT_DONE] |-> out_tdata[OUT_R_LO+VEL_W-1:0] == '0)
    else $error("move_done with nonzero drive");

  // saturation never yields the lone negative code
  a_sat_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[OUT_L_LO +: VEL_W] != 11'h400 &&
                   out_tdata[OUT_R_LO +: VEL_W] != 11'h400)
    else $error("velocity outside +-1023");

  // a result never appears without a preceding input transfer
  a_latency: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid && !$past(in_tvalid && in_tready) |=> !out_tvalid)
    else $error("result without a preceding transfer");

  // nothing comes out right after reset
  a_reset: assert property (@(posedge clk) !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

endmodule

bind slew_limited_drive_profiler_unit sldp_checker u_sldp_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

FILE: test/sldp_drive_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sldp_drive_checker
// Watches the tick, command and register channels of the drive profiler,
// keeps its own copy of the registers and of the running power, predicts the
// drive command of every accepted tick and compares it with the command that
// leaves the block, in order.
// ----------------------------------------------------------------------------
module sldp_drive_checker
  import sldp_pkg::*;
#(
  parameter int unsigned TICK_BITS       = 20,
  parameter int unsigned POWER_FRAC_BITS = 20,
  localparam int unsigned IN_W = ((1 + 2 * TICK_BITS + 7) / 8) * 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  input  logic                  in_tready,
  input  logic [IN_W-1:0]       in_tdata,
  input  logic                  out_tvalid,
  input  logic                  out_tready,
  input  logic [OUT_W-1:0]      out_tdata,
  input  logic                  cfg_valid,
  input  logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           mismatch_count,
  output int unsigned           cmds_outstanding
);

  typedef struct packed {
    logic             done;
    logic [VEL_W-1:0] right_vel;
    logic [VEL_W-1:0] left_vel;
  } drive_cmd_t;

  logic [TGT_W-1:0]   target_reg;
  logic [GAIN_W-1:0]  dist_gain_reg;
  logic [DECEL_W-1:0] decel_gain_reg;
  logic [SLEW_W-1:0]  slew_reg;
  logic [GAIN_W-1:0]  align_gain_reg;
  logic [PWR_W-1:0]   min_power_reg;
  logic [PWR_W-1:0]   power_cap_reg;
  dir_mode_t          dir_reg;
  longint             running_power;   // Q.POWER_FRAC_BITS, never negative
  drive_cmd_t         drive_cmd_q[$];

  function automatic longint to_power_scale(input longint v, input int frac);
    if (POWER_FRAC_BITS >= frac)
      return v <<< (POWER_FRAC_BITS - frac);
    return v >>> (frac - POWER_FRAC_BITS);
  endfunction

  // truncate toward zero, saturate to +-OUT_MAX
  function automatic logic [VEL_W-1:0] to_velocity(input longint p);
    longint           whole;
    logic [VEL_W-1:0] v;
    whole = (p < 0) ? -p : p;
    whole = whole >>> POWER_FRAC_BITS;
    if (whole > longint'(OUT_MAX))
      whole = longint'(OUT_MAX);
    v = whole[VEL_W-1:0];
    if (p < 0)
      v = -v;
    return v;
  endfunction

  function automatic drive_cmd_t profile_tick(input logic start_bit,
                                              input logic [TICK_BITS-1:0] lt,
                                              input logic [TICK_BITS-1:0] rt);
    longint     tgt, avg, remaining, pwr_step, slew, lhs, hi, floor_pwr;
    longint     pwr, diff, align, lp, rp, cap, frac_mask;
    int         dsh;
    drive_cmd_t cmd;
    cmd = '0;
    dsh = POWER_FRAC_BITS + DECEL_FRAC;
    tgt = longint'(target_reg) & ((64'sd1 <<< TICK_BITS) - 1);
    avg = (longint'(lt) + longint'(rt)) >>> 1;
    if (start_bit)
      running_power = 0;
    if (avg >= tgt) begin
      running_power = 0;
      cmd.done = 1'b1;
      return cmd;
    end
    remaining = tgt - avg;
    pwr_step = to_power_scale(remaining * longint'(dist_gain_reg), GAIN_FRAC);
    slew = to_power_scale(longint'(slew_reg), SLEW_FRAC);
    if (pwr_step > slew)
      pwr_step = slew;
    // decel when power * decel_gain exceeds the remaining distance, exactly
    lhs = running_power * longint'(decel_gain_reg);
    hi = lhs >>> dsh;
    frac_mask = (64'sd1 <<< dsh) - 1;
    if (hi > remaining || (hi == remaining && (lhs & frac_mask) != 0)) begin
      pwr_step = -pwr_step;
      floor_pwr = longint'(min_power_reg) <<< POWER_FRAC_BITS;
      if (running_power < floor_pwr)
        pwr_step = floor_pwr - running_power;
    end
    pwr = running_power + pwr_step;
    diff = (lt > rt) ? longint'(lt) - longint'(rt) : longint'(rt) - longint'(lt);
    align = to_power_scale(diff * longint'(align_gain_reg), GAIN_FRAC);
    lp = pwr;
    rp = pwr;
    if (lt > rt)
      lp = pwr - align;
    else if (rt > lt)
      rp = pwr - align;
    case (dir_reg)
      DIR_BACKWARD: begin
        lp = -lp;
        rp = -rp;
      end
      DIR_SPIN_LEFT:  lp = -lp;
      DIR_SPIN_RIGHT: rp = -rp;
      default: ;
    endcase
    cap = longint'(power_cap_reg) <<< POWER_FRAC_BITS;
    if (pwr > cap)
      pwr = cap;
    else if (pwr < 0)
      pwr = 0;
    running_power = pwr;
    cmd.left_vel = to_velocity(lp);
    cmd.right_vel = to_velocity(rp);
    return cmd;
  endfunction

  always @(posedge clk) begin
    drive_cmd_t got;
    drive_cmd_t want;
    if (!rst_n) begin
      target_reg = RST_TARGET_TICKS;
      dist_gain_reg = RST_DIST_GAIN;
      decel_gain_reg = RST_DECEL_GAIN;
      slew_reg = RST_SLEW_LIMIT;
      align_gain_reg = RST_ALIGN_GAIN;
      min_power_reg = RST_MIN_POWER;
      power_cap_reg = RST_POWER_CAP;
      dir_reg = DIR_FORWARD;
      running_power = 0;
      drive_cmd_q.delete();
      mismatch_count = 0;
      cmds_outstanding = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_TARGET_TICKS:   target_reg = cfg_data[TGT_W-1:0];
          REG_DIST_GAIN:      dist_gain_reg = cfg_data[GAIN_W-1:0];
          REG_DECEL_GAIN:     decel_gain_reg = cfg_data[DECEL_W-1:0];
          REG_SLEW_LIMIT:     slew_reg = cfg_data[SLEW_W-1:0];
          REG_ALIGN_GAIN:     align_gain_reg = cfg_data[GAIN_W-1:0];
          REG_MIN_POWER:      min_power_reg = cfg_data[PWR_W-1:0];
          REG_POWER_CAP:      power_cap_reg = cfg_data[PWR_W-1:0];
          REG_DIRECTION_MODE: dir_reg = dir_mode_t'(cfg_data[1:0]);
          default: ;
        endcase
      end
      if (in_tvalid && in_tready)
        drive_cmd_q.push_back(profile_tick(in_tdata[0], in_tdata[TICK_BITS:1],
                                           in_tdata[2*TICK_BITS:TICK_BITS+1]));
      if (out_tvalid && out_tready) begin
        got.left_vel = out_tdata[OUT_L_LO +: VEL_W];
        got.right_vel = out_tdata[OUT_R_LO +: VEL_W];
        got.done = out_tdata[OUT_DONE];
        if (drive_cmd_q.size() == 0) begin
          if (mismatch_count < 10)
            $display("%0t: unexpected drive command L=%0d R=%0d done=%0b", $time,
                     $signed(got.left_vel), $signed(got.right_vel), got.done);
          mismatch_count++;
        end else begin
          want = drive_cmd_q.pop_front();
          if (got != want) begin
            if (mismatch_count < 10)
              $display("%0t: drive command mismatch: expected L=%0d R=%0d done=%0b, got L=%0d R=%0d done=%0b",
                       $time, $signed(want.left_vel), $signed(want.right_vel), want.done,
                       $signed(got.left_vel), $signed(got.right_vel), got.done);
            mismatch_count++;
          end
        end
      end
      cmds_outstanding = drive_cmd_q.size();
    end
  end

endmodule

FILE: test/slew_limited_drive_profiler_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// slew_limited_drive_profiler_unit_tb
// Regression for the drive profiler: a directed run over register and tick
// extremes, then encoder-style moves toward the target mixed with random
// ticks, under several register settings and three idle patterns, with one
// long output back-pressure stretch. Checking is done by sldp_drive_checker.
// ----------------------------------------------------------------------------
module slew_limited_drive_profiler_unit_tb;
  import sldp_pkg::*;

  localparam int unsigned TICK_BITS       = 20;
  localparam int unsigned POWER_FRAC_BITS = 20;
  localparam int unsigned IN_W            = ((1 + 2 * TICK_BITS + 7) / 8) * 8;
  localparam int unsigned RESET_CYCLES    = 5;
  localparam int unsigned HOLD_CYCLES     = 300;
  localparam int unsigned QUIET_LIMIT     = 5000;
  localparam int unsigned DRAIN_CYCLES    = 4;
  localparam int unsigned PHASE_TICKS     = 70;
  localparam int unsigned MAX_MOVE_TICKS  = 24;
  localparam int unsigned NUM_PHASES      = 9;

  typedef enum {SET_RANGE_MAX, SET_ZERO, SET_ALL_ONES, SET_TYPICAL, SET_WILD} setting_kind_t;

  typedef struct {
    logic [CFG_DATA_W-1:0] target;
    logic [CFG_DATA_W-1:0] dist_gain;
    logic [CFG_DATA_W-1:0] decel_gain;
    logic [CFG_DATA_W-1:0] slew;
    logic [CFG_DATA_W-1:0] align_gain;
    logic [CFG_DATA_W-1:0] min_power;
    logic [CFG_DATA_W-1:0] power_cap;
    logic [CFG_DATA_W-1:0] dir;
  } prof_setting_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [IN_W-1:0]       in_tdata = '0;
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [OUT_W-1:0]      out_tdata;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  int unsigned mismatch_count;
  int unsigned cmds_outstanding;
  int unsigned tx_idle_pct = 6;
  int unsigned rx_idle_pct = 88;
  int unsigned quiet_cycles = 0;
  int unsigned ticks_sent = 0;
  bit          hold_req = 1'b0;
  bit          hold_served = 1'b0;
  longint      cur_target = 0;

  always #10 clk = ~clk;

  slew_limited_drive_profiler_unit #(
    .TICK_BITS       (TICK_BITS),
    .POWER_FRAC_BITS (POWER_FRAC_BITS)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  sldp_drive_checker #(
    .TICK_BITS       (TICK_BITS),
    .POWER_FRAC_BITS (POWER_FRAC_BITS)
  ) u_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_tvalid        (in_tvalid),
    .in_tready        (in_tready),
    .in_tdata         (in_tdata),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_tdata        (out_tdata),
    .cfg_valid        (cfg_valid),
    .cfg_ready        (cfg_ready),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data),
    .mismatch_count   (mismatch_count),
    .cmds_outstanding (cmds_outstanding)
  );

  // command side: random stalls, plus one long hold-off once requested
  initial begin : rx_side
    int unsigned held;
    forever begin
      @(posedge clk);
      if (hold_req && !hold_served) begin
        out_tready <= 1'b0;
        for (held = 0; held < HOLD_CYCLES; held++)
          @(posedge clk);
        hold_served = 1'b1;
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
        quiet_cycles <= 0;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
          $display("slew_limited_drive_profiler_unit regression: fail");
          $finish;
        end
      end
    end
  end

  function automatic logic [TICK_BITS-1:0] tick_clamp(input longint v);
    longint top_v;
    top_v = (64'sd1 <<< TICK_BITS) - 1;
    if (v > top_v)
      v = top_v;
    return v[TICK_BITS-1:0];
  endfunction

  function automatic prof_setting_t make_setting(input setting_kind_t kind, input dir_mode_t dir);
    prof_setting_t s;
    case (kind)
      SET_RANGE_MAX: begin
        s.target = 20'hFFFFF;
        s.dist_gain = 20'hFFFF;
        s.decel_gain = 20'hFFF;
        s.slew = 20'hFFFFF;
        s.align_gain = 20'hFFFF;
        s.min_power = 20'd600;
        s.power_cap = 20'd1023;
      end
      SET_ZERO: begin
        s.target = '0;
        s.dist_gain = '0;
        s.decel_gain = '0;
        s.slew = '0;
        s.align_gain = '0;
        s.min_power = '0;
        s.power_cap = '0;
      end
      SET_ALL_ONES: begin
        s.target = '1;
        s.dist_gain = '1;
        s.decel_gain = '1;
        s.slew = '1;
        s.align_gain = '1;
        s.min_power = '1;
        s.power_cap = '1;
      end
      SET_TYPICAL: begin
        s.target = CFG_DATA_W'($urandom_range(20000, 200));
        s.dist_gain = CFG_DATA_W'($urandom_range(65535, 100));
        s.decel_gain = CFG_DATA_W'($urandom_range(4095));
        s.slew = CFG_DATA_W'($urandom_range(1048575, 50000));
        s.align_gain = CFG_DATA_W'($urandom_range(20000));
        s.min_power = CFG_DATA_W'($urandom_range(600));
        s.power_cap = CFG_DATA_W'($urandom_range(60, 1));
      end
      default: begin
        s.target = CFG_DATA_W'($urandom());
        s.dist_gain = CFG_DATA_W'($urandom());
        s.decel_gain = CFG_DATA_W'($urandom());
        s.slew = CFG_DATA_W'($urandom());
        s.align_gain = CFG_DATA_W'($urandom());
        s.min_power = CFG_DATA_W'($urandom());
        s.power_cap = CFG_DATA_W'($urandom());
      end
    endcase
    case (kind)
      SET_ALL_ONES: s.dir = '1;
      SET_WILD:     s.dir = CFG_DATA_W'($urandom());
      default:      s.dir = CFG_DATA_W'(dir);
    endcase
    return s;
  endfunction

  task automatic cfg_put(input cfg_reg_t idx, input logic [CFG_DATA_W-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready)
      @(posedge clk);
  endtask

  task automatic apply_setting(input prof_setting_t s);
    cfg_put(REG_TARGET_TICKS, s.target);
    cfg_put(REG_DIST_GAIN, s.dist_gain);
    cfg_put(REG_DECEL_GAIN, s.decel_gain);
    cfg_put(REG_SLEW_LIMIT, s.slew);
    cfg_put(REG_ALIGN_GAIN, s.align_gain);
    cfg_put(REG_MIN_POWER, s.min_power);
    cfg_put(REG_POWER_CAP, s.power_cap);
    cfg_put(REG_DIRECTION_MODE, s.dir);
    cfg_valid <= 1'b0;
    cur_target = longint'(s.target[TGT_W-1:0]) & ((64'sd1 <<< TICK_BITS) - 1);
  endtask

  // valid stays up between back-to-back transfers
  task automatic send_tick(input logic start_bit, input logic [TICK_BITS-1:0] lt,
                           input logic [TICK_BITS-1:0] rt);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {{(IN_W - 2 * TICK_BITS - 1){1'b0}}, rt, lt, start_bit};
    @(posedge clk);
    while (!in_tready)
      @(posedge clk);
    ticks_sent++;
  endtask

  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (cmds_outstanding != 0)
      @(posedge clk);
  endtask

  // encoder-like approach: positions close in on the target, then reach or pass it
  task automatic run_move();
    longint      pos;
    longint      rem;
    int unsigned spread;
    int unsigned k;
    logic        start_bit;
    pos = (cur_target == 0) ? 0 : $urandom_range(int'(cur_target / 2));
    for (k = 0; k < MAX_MOVE_TICKS && pos < cur_target; k++) begin
      spread = ($urandom_range(15) == 0) ? $urandom_range(4095) : $urandom_range(7);
      start_bit = (k == 0) || ($urandom_range(31) == 0);
      case ($urandom_range(2))
        0:       send_tick(start_bit, tick_clamp(pos + spread), tick_clamp(pos));
        1:       send_tick(start_bit, tick_clamp(pos), tick_clamp(pos + spread));
        default: send_tick(start_bit, tick_clamp(pos), tick_clamp(pos));
      endcase
      rem = cur_target - pos;
      pos += $urandom_range((rem / 4 > 1) ? int'(rem / 4) : 1, 1);
    end
    send_tick(1'b0, tick_clamp(cur_target + $urandom_range(3)),
              tick_clamp(cur_target + $urandom_range(3)));
  endtask

  task automatic run_phase(input prof_setting_t s);
    int unsigned first;
    apply_setting(s);
    first = ticks_sent;
    while (ticks_sent - first < PHASE_TICKS) begin
      if ($urandom_range(99) < 80)
        run_move();
      else
        send_tick(1'($urandom_range(1)), TICK_BITS'($urandom()), TICK_BITS'($urandom()));
    end
    drain();
  endtask

  initial begin : stimulus
    setting_kind_t plan_kind [NUM_PHASES];
    dir_mode_t     plan_dir [NUM_PHASES];
    prof_setting_t s;
    int unsigned   ph;
    plan_kind = '{SET_TYPICAL, SET_RANGE_MAX, SET_TYPICAL,
                  SET_WILD, SET_TYPICAL, SET_ALL_ONES,
                  SET_TYPICAL, SET_ZERO, SET_TYPICAL};
    plan_dir = '{DIR_FORWARD, DIR_BACKWARD, DIR_SPIN_LEFT,
                 DIR_SPIN_RIGHT, DIR_SPIN_RIGHT, DIR_SPIN_RIGHT,
                 DIR_BACKWARD, DIR_FORWARD, DIR_SPIN_LEFT};

    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;

    // target is zero out of reset: every tick ends the move
    send_tick(1'b0, '0, '0);
    send_tick(1'b1, '1, '1);
    drain();

    // top of every range, backward: huge alignment saturates, floor near the end
    s = make_setting(SET_RANGE_MAX, DIR_BACKWARD);
    apply_setting(s);
    send_tick(1'b1, '0, '0);
    send_tick(1'b0, '1, '0);
    send_tick(1'b0, '0, '1);
    send_tick(1'b0, 20'h7FFFF, 20'h7FFFF);
    send_tick(1'b0, 20'hFFFFD, 20'hFFFFD);
    send_tick(1'b0, 20'hFFFFE, 20'hFFFFE);
    send_tick(1'b1, 20'hFFFFE, 20'hFFFFF);
    send_tick(1'b0, 20'hFFFFF, 20'hFFFFE);
    send_tick(1'b0, '1, '1);
    drain();

    // spin left, tiny cap and floor, decel gain of one
    s.target = 20'd1000;
    s.dist_gain = 20'hFFFF;
    s.decel_gain = 20'd256;
    s.slew = 20'hFFFFF;
    s.align_gain = 20'hFFFF;
    s.min_power = 20'd3;
    s.power_cap = 20'd2;
    s.dir = CFG_DATA_W'(DIR_SPIN_LEFT);
    apply_setting(s);
    send_tick(1'b1, '0, '0);
    send_tick(1'b0, 20'd10, 20'd0);
    send_tick(1'b0, 20'd0, 20'd10);
    send_tick(1'b0, 20'd500, 20'd500);
    send_tick(1'b0, 20'd997, 20'd997);
    send_tick(1'b0, 20'd998, 20'd999);
    send_tick(1'b0, 20'd999, 20'd999);
    send_tick(1'b0, 20'd1000, 20'd1000);
    drain();

    // spin right, no decel, full cap, no floor
    s.decel_gain = '0;
    s.min_power = '0;
    s.power_cap = 20'd1023;
    s.dir = CFG_DATA_W'(DIR_SPIN_RIGHT);
    apply_setting(s);
    send_tick(1'b1, 20'd100, 20'd90);
    send_tick(1'b0, 20'd90, 20'd100);
    send_tick(1'b0, 20'd600, 20'd600);
    send_tick(1'b0, 20'd0, 20'd1999);
    send_tick(1'b1, 20'd0, 20'd2000);
    drain();

    for (ph = 0; ph < NUM_PHASES; ph++) begin
      if (ph == 3) begin
        tx_idle_pct = 88;
        rx_idle_pct = 6;
      end else if (ph == 6) begin
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        hold_req = 1'b1;
      end
      run_phase(make_setting(plan_kind[ph], plan_dir[ph]));
    end

    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && cmds_outstanding == 0)
      $display("slew_limited_drive_profiler_unit regression: pass");
    else
      $display("slew_limited_drive_profiler_unit regression: fail");
    $finish;
  end

endmodule
